// File: rtl/core/fecrs_pkg.sv
`timescale 1ns / 1ps
package fecrs_pkg;

	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int WIN_W      = 7;
	localparam int WIN_CAP    = (RING_DEPTH < 64) ? RING_DEPTH : 64;
	localparam int CNT_W      = 7;
	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;
	localparam logic [31:0] MEAN_THRESH = 32'd32;
	localparam logic [15:0] LEN_TAG     = 16'd8;
	localparam int INFO_SHIFT = 24;
	localparam int PADDR_W    = 4;
	localparam int MEAN_STEP  = 20;

	localparam logic [6:0]  MAX_WINDOW_RST  = 7'd20;
	localparam logic [8:0]  WINDOW_STEP_RST = 9'h1FF;
	localparam logic [15:0] ALPHA_RST       = 16'd49152;
	localparam logic [15:0] BETA_RST        = 16'd0;

	typedef enum logic [1:0] {
		REG_MAX_WINDOW  = 2'd0,
		REG_WINDOW_STEP = 2'd1,
		REG_ALPHA       = 2'd2,
		REG_BETA        = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_SRC,
		OP_RATE_A,
		OP_RATE_B,
		OP_DECIDE,
		OP_MAX,
		OP_EMIT,
		OP_DIV_M_INIT,
		OP_DIV_STEP,
		OP_SET_M,
		OP_BLEND_A_MEAN,
		OP_BLEND_B_MEAN,
		OP_SET_E2,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_BLEND_A_STD,
		OP_BLEND_B_STD
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic due;
		logic max_done;
		logic div_last;
		logic sqrt_last;
		logic fb_ok;
		logic var_pos;
		logic out_busy;
	} sts_t;

	typedef struct packed {
		logic       wr;
		reg_idx_t   idx;
		logic [31:0] data;
	} cfg_wr_t;

	function automatic logic [WIN_W-1:0] win_limit(input logic [WIN_W-1:0] mw);
		logic [WIN_W-1:0] r;
		r = mw;
		if (r == '0) r = WIN_W'(1);
		if (r > WIN_W'(WIN_CAP)) r = WIN_W'(WIN_CAP);
		return r;
	endfunction

	function automatic logic [31:0] init_mean(input logic [WIN_W-1:0] mw);
		logic [WIN_W-1:0] q;
		q = '0;
		for (int k = 1; k <= 6; k++)
			if (mw >= WIN_W'(k * MEAN_STEP)) q = WIN_W'(k);
		return {9'd0, q + WIN_W'(1), 16'd0};
	endfunction

endpackage

// File: rtl/core/fecrs_if.sv
`timescale 1ns / 1ps
interface fecrs_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] pkt_length;
	logic [7:0]  fb_window;
	logic [15:0] fb_active_windows;
	logic [15:0] fb_losses;
	logic [31:0] fb_losses_squared;

	modport source (output valid, action, pkt_length, fb_window, fb_active_windows,
		fb_losses, fb_losses_squared, input ready);
	modport sink (input valid, action, pkt_length, fb_window, fb_active_windows,
		fb_losses, fb_losses_squared, output ready);
endinterface

interface fecrs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_id;
	logic        send_repair;
	logic [6:0]  repair_window;
	logic [31:0] repair_info;
	logic [15:0] repair_length;

	modport source (output valid, source_id, send_repair, repair_window, repair_info,
		repair_length, input ready);
	modport sink (input valid, source_id, send_repair, repair_window, repair_info,
		repair_length, output ready);
endinterface

// File: rtl/core/fecrs_dp.sv
`timescale 1ns / 1ps
module fecrs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fecrs_pkg::cmd_t      cmd,
	output fecrs_pkg::sts_t      sts,
	input  fecrs_pkg::cfg_wr_t   cfg,
	output logic [6:0]           max_window,
	output logic [8:0]           window_step,
	output logic [15:0]          alpha,
	output logic [15:0]          beta,
	input  logic [15:0]          in_pkt_length,
	input  logic [7:0]           in_fb_window,
	input  logic [15:0]          in_fb_active_windows,
	input  logic [15:0]          in_fb_losses,
	input  logic [31:0]          in_fb_losses_squared,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [31:0]          out_source_id,
	output logic                 out_send_repair,
	output logic [6:0]           out_repair_window,
	output logic [31:0]          out_repair_info,
	output logic [15:0]          out_repair_length
);

	logic [6:0]  max_window_q;
	logic [8:0]  window_step_q;
	logic [15:0] alpha_q, beta_q;
	logic [31:0] symbol_id_q, last_repair_q, repair_key_q, mean_q, std_q;
	logic [fecrs_pkg::WIN_W-1:0] ws_q;
	logic [15:0] ring_mem [fecrs_pkg::RING_DEPTH];
	logic [15:0] rd_data_q;
	logic [15:0] len_q;
	logic [7:0]  fbw_q;
	logic [15:0] act_q, los_q;
	logic [31:0] sq_q;
	logic [31:0] src_id_q;
	logic [47:0] prod_q;
	logic [31:0] d_q;
	logic [17:0] g_q;
	logic        step_hit_q;
	logic [49:0] gd_q;
	logic        due_q;
	logic [15:0] best_q;
	logic [fecrs_pkg::CNT_W-1:0] cnt_q;
	logic [63:0] dvd_q;
	logic [15:0] rem_q;
	logic [31:0] m_q;
	logic [63:0] e2_q, msq_q;
	logic [63:0] v_q, res_q, bit_q;
	logic [47:0] p1_q;
	logic        out_valid_q;

	logic [16:0] len_sum;
	logic [15:0] len_sat;
	logic [31:0] gap;
	logic [48:0] d_full;
	logic [31:0] start;
	logic [fecrs_pkg::RING_AW-1:0] rd_addr;
	logic [16:0] rem_sh;
	logic        q_bit;
	logic [63:0] sq_t;
	logic [31:0] bl_fb;
	logic [48:0] p2;
	logic [49:0] bl_sum;
	logic [31:0] bl_res;
	logic        emit_go;

	assign len_sum = {1'b0, in_pkt_length} + {1'b0, fecrs_pkg::LEN_TAG};
	assign len_sat = len_sum[16] ? 16'hFFFF : len_sum[15:0];
	assign gap     = symbol_id_q - last_repair_q;
	assign d_full  = {1'b0, mean_q, 8'd0} + {1'b0, prod_q};
	assign start   = symbol_id_q - {25'd0, ws_q};
	assign rd_addr = fecrs_pkg::RING_AW'(start + {25'd0, cnt_q});
	assign rem_sh  = {rem_q, dvd_q[63]};
	assign q_bit   = rem_sh >= {1'b0, act_q};
	assign sq_t    = res_q + bit_q;
	assign bl_fb   = (cmd.op == fecrs_pkg::OP_BLEND_B_STD) ? res_q[31:0] : m_q;
	assign p2      = (17'h10000 - {1'b0, alpha_q}) * bl_fb;
	assign bl_sum  = {2'b0, p1_q} + {1'b0, p2};
	assign bl_res  = bl_sum[47:16];
	assign emit_go = (cmd.op == fecrs_pkg::OP_EMIT) && !sts.out_busy;

	always_comb begin
		sts.due       = due_q;
		sts.max_done  = cnt_q == ws_q;
		sts.div_last  = cnt_q == fecrs_pkg::CNT_W'(fecrs_pkg::DIV_STEPS - 1);
		sts.sqrt_last = cnt_q == fecrs_pkg::CNT_W'(fecrs_pkg::SQRT_STEPS - 1);
		sts.fb_ok     = (fbw_q == {1'b0, max_window_q}) && (act_q != '0);
		sts.var_pos   = e2_q > msq_q;
		sts.out_busy  = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == fecrs_pkg::OP_SRC)
			ring_mem[fecrs_pkg::RING_AW'(symbol_id_q)] <= len_q;
		rd_data_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_window_q  <= fecrs_pkg::MAX_WINDOW_RST;
			window_step_q <= fecrs_pkg::WINDOW_STEP_RST;
			alpha_q       <= fecrs_pkg::ALPHA_RST;
			beta_q        <= fecrs_pkg::BETA_RST;
			symbol_id_q   <= '0;
			last_repair_q <= '0;
			repair_key_q  <= '0;
			ws_q          <= '0;
			mean_q        <= fecrs_pkg::init_mean(fecrs_pkg::MAX_WINDOW_RST);
			std_q         <= '0;
			out_valid_q   <= 1'b0;
			due_q         <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (cfg.wr) begin
				case (cfg.idx)
					fecrs_pkg::REG_MAX_WINDOW: begin
						max_window_q <= cfg.data[6:0];
						mean_q       <= fecrs_pkg::init_mean(cfg.data[6:0]);
					end
					fecrs_pkg::REG_WINDOW_STEP: window_step_q <= cfg.data[8:0];
					fecrs_pkg::REG_ALPHA:       alpha_q <= cfg.data[15:0];
					fecrs_pkg::REG_BETA:        beta_q <= cfg.data[15:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				fecrs_pkg::OP_SRC: begin
					symbol_id_q <= symbol_id_q + 32'd1;
					if (ws_q < fecrs_pkg::win_limit(max_window_q))
						ws_q <= ws_q + fecrs_pkg::WIN_W'(1);
				end
				fecrs_pkg::OP_DECIDE: begin
					due_q <= step_hit_q || ((mean_q > fecrs_pkg::MEAN_THRESH) &&
						(gd_q >= {19'd0, ws_q, 24'd0}));
					cnt_q <= '0;
				end
				fecrs_pkg::OP_MAX: begin
					cnt_q <= cnt_q + fecrs_pkg::CNT_W'(1);
					if (due_q && cnt_q == '0)
						last_repair_q <= symbol_id_q;
				end
				fecrs_pkg::OP_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						if (due_q)
							repair_key_q <= repair_key_q + 32'd1;
					end
				end
				fecrs_pkg::OP_DIV_M_INIT, fecrs_pkg::OP_BLEND_B_MEAN,
				fecrs_pkg::OP_SQRT_INIT: begin
					cnt_q <= '0;
					if (cmd.op == fecrs_pkg::OP_BLEND_B_MEAN)
						mean_q <= bl_res;
				end
				fecrs_pkg::OP_DIV_STEP, fecrs_pkg::OP_SQRT_STEP:
					cnt_q <= cnt_q + fecrs_pkg::CNT_W'(1);
				fecrs_pkg::OP_BLEND_B_STD: std_q <= bl_res;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q  <= len_sat;
			fbw_q  <= in_fb_window;
			act_q  <= in_fb_active_windows;
			los_q  <= in_fb_losses;
			sq_q   <= in_fb_losses_squared;
		end
		case (cmd.op)
			fecrs_pkg::OP_SRC: begin
				src_id_q <= symbol_id_q;
				prod_q   <= beta_q * std_q;
			end
			fecrs_pkg::OP_RATE_A: begin
				d_q <= (d_full > 49'h80000000) ? 32'h80000000 : d_full[31:0];
				g_q <= (gap > 32'h20000) ? 18'h20000 : gap[17:0];
				step_hit_q <= !window_step_q[8] && (gap >= {24'd0, window_step_q[7:0]});
			end
			fecrs_pkg::OP_RATE_B: gd_q <= g_q * d_q;
			fecrs_pkg::OP_DECIDE: best_q <= '0;
			fecrs_pkg::OP_MAX: begin
				if (cnt_q != '0 && rd_data_q > best_q)
					best_q <= rd_data_q;
			end
			fecrs_pkg::OP_EMIT: begin
				if (emit_go) begin
					out_source_id     <= src_id_q;
					out_send_repair   <= due_q;
					out_repair_window <= due_q ? ws_q : '0;
					out_repair_info   <= due_q ? ({25'd0, ws_q} << fecrs_pkg::INFO_SHIFT) +
						repair_key_q : '0;
					out_repair_length <= due_q ? best_q : '0;
				end
			end
			fecrs_pkg::OP_DIV_M_INIT: begin
				dvd_q <= {32'd0, los_q, 16'd0};
				rem_q <= '0;
			end
			fecrs_pkg::OP_DIV_STEP: begin
				rem_q <= q_bit ? 16'(rem_sh - {1'b0, act_q}) : rem_sh[15:0];
				dvd_q <= {dvd_q[62:0], q_bit};
			end
			fecrs_pkg::OP_SET_M: m_q <= dvd_q[31:0];
			fecrs_pkg::OP_BLEND_A_MEAN: p1_q <= alpha_q * mean_q;
			fecrs_pkg::OP_BLEND_B_MEAN: begin
				dvd_q <= {sq_q, 32'd0};
				rem_q <= '0;
			end
			fecrs_pkg::OP_SET_E2: begin
				e2_q  <= dvd_q;
				msq_q <= m_q * m_q;
			end
			fecrs_pkg::OP_SQRT_INIT: begin
				v_q   <= e2_q - msq_q;
				res_q <= '0;
				bit_q <= 64'h4000000000000000;
			end
			fecrs_pkg::OP_SQRT_STEP: begin
				if (v_q >= sq_t) begin
					v_q   <= v_q - sq_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			fecrs_pkg::OP_BLEND_A_STD: p1_q <= alpha_q * std_q;
			default: ;
		endcase
	end

	assign max_window  = max_window_q;
	assign window_step = window_step_q;
	assign alpha       = alpha_q;
	assign beta        = beta_q;
	assign out_valid   = out_valid_q;

`ifndef ASSERT_OFF
	a_ws_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ws_q <= fecrs_pkg::WIN_W'(fecrs_pkg::WIN_CAP))
		else $error("window above cap");
	a_key_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && due_q |=> repair_key_q == $past(repair_key_q) + 32'd1)
		else $error("repair key not advanced");
	a_no_repair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_send_repair |-> out_repair_window == '0 &&
		out_repair_info == '0 && out_repair_length == '0)
		else $error("repair fields set without repair");
	a_sym_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == fecrs_pkg::OP_SRC |=> symbol_id_q == $past(symbol_id_q) + 32'd1)
		else $error("symbol id not advanced");
`endif

endmodule

// File: rtl/core/fecrs_ctrl.sv
`timescale 1ns / 1ps
module fecrs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_action,
	output logic            in_ready,
	input  fecrs_pkg::sts_t sts,
	output fecrs_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SRC, ST_RA, ST_RB, ST_DEC, ST_MAX, ST_EMIT,
		ST_FCHK, ST_DIVM, ST_SETM, ST_BAM, ST_BBM, ST_DIVE, ST_SETE,
		ST_VCHK, ST_SQRT, ST_BAS, ST_BBS
	} state_t;

	state_t state_q;

	assign in_ready = state_q == ST_IDLE;
	assign cmd.load = in_valid && in_ready;

	always_comb begin
		case (state_q)
			ST_SRC:  cmd.op = fecrs_pkg::OP_SRC;
			ST_RA:   cmd.op = fecrs_pkg::OP_RATE_A;
			ST_RB:   cmd.op = fecrs_pkg::OP_RATE_B;
			ST_DEC:  cmd.op = fecrs_pkg::OP_DECIDE;
			ST_MAX:  cmd.op = fecrs_pkg::OP_MAX;
			ST_EMIT: cmd.op = fecrs_pkg::OP_EMIT;
			ST_FCHK: cmd.op = fecrs_pkg::OP_DIV_M_INIT;
			ST_DIVM, ST_DIVE: cmd.op = fecrs_pkg::OP_DIV_STEP;
			ST_SETM: cmd.op = fecrs_pkg::OP_SET_M;
			ST_BAM:  cmd.op = fecrs_pkg::OP_BLEND_A_MEAN;
			ST_BBM:  cmd.op = fecrs_pkg::OP_BLEND_B_MEAN;
			ST_SETE: cmd.op = fecrs_pkg::OP_SET_E2;
			ST_VCHK: cmd.op = fecrs_pkg::OP_SQRT_INIT;
			ST_SQRT: cmd.op = fecrs_pkg::OP_SQRT_STEP;
			ST_BAS:  cmd.op = fecrs_pkg::OP_BLEND_A_STD;
			ST_BBS:  cmd.op = fecrs_pkg::OP_BLEND_B_STD;
			default: cmd.op = fecrs_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= in_action ? ST_FCHK : ST_SRC;
				ST_SRC:  state_q <= ST_RA;
				ST_RA:   state_q <= ST_RB;
				ST_RB:   state_q <= ST_DEC;
				ST_DEC:  state_q <= ST_MAX;
				ST_MAX:  if (sts.max_done || !sts.due) state_q <= ST_EMIT;
				ST_EMIT: if (!sts.out_busy) state_q <= ST_IDLE;
				ST_FCHK: state_q <= sts.fb_ok ? ST_DIVM : ST_IDLE;
				ST_DIVM: if (sts.div_last) state_q <= ST_SETM;
				ST_SETM: state_q <= ST_BAM;
				ST_BAM:  state_q <= ST_BBM;
				ST_BBM:  state_q <= ST_DIVE;
				ST_DIVE: if (sts.div_last) state_q <= ST_SETE;
				ST_SETE: state_q <= ST_VCHK;
				ST_VCHK: state_q <= sts.var_pos ? ST_SQRT : ST_IDLE;
				ST_SQRT: if (sts.sqrt_last) state_q <= ST_BAS;
				ST_BAS:  state_q <= ST_BBS;
				ST_BBS:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !in_action |=> state_q == ST_SRC)
		else $error("source word not started");
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !sts.out_busy |=> state_q == ST_IDLE)
		else $error("emit stuck");
	a_fb_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && in_action |=> state_q == ST_FCHK)
		else $error("feedback word not started");
`endif

endmodule

// File: rtl/core/fec_repair_scheduler.sv
`timescale 1ns / 1ps
// channel | dir | words
// in_ch   | in  | action, pkt_length, fb_window, fb_active_windows, fb_losses, fb_losses_squared
// out_ch  | out | source_id, send_repair, repair_window, repair_info, repair_length
// apb     | in  | register writes and reads, 4 regs at byte addresses 0,4,8,12
// Source word: accept, then states SRC, RA, RB, DEC, MAX and EMIT; with a repair, MAX scans
// the window (ring read, one entry a cycle); the next word is taken the cycle after the result loads.
// Feedback word: unless ignored, it runs the shared radix-2 divider (64 steps, run twice),
// then the 32-step square root if the variance is positive.
// One word at a time; the next word is taken while a result waits in the output register.
// Async active-low reset clears control state and loads register defaults.
module fec_repair_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fecrs_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	fecrs_in_if.sink                        in_ch,
	fecrs_out_if.source                     out_ch
);

	fecrs_pkg::cmd_t    cmd;
	fecrs_pkg::sts_t    sts;
	fecrs_pkg::cfg_wr_t cfg;
	fecrs_pkg::reg_idx_t ridx;
	logic [6:0]  max_window;
	logic [8:0]  window_step;
	logic [15:0] alpha, beta;

	assign pready   = 1'b1;
	assign ridx     = fecrs_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg.wr   = psel && penable && pwrite;
	assign cfg.idx  = ridx;
	assign cfg.data = pwdata;

	always_comb begin
		case (ridx)
			fecrs_pkg::REG_MAX_WINDOW:  prdata = {25'd0, max_window};
			fecrs_pkg::REG_WINDOW_STEP: prdata = {{23{window_step[8]}}, window_step};
			fecrs_pkg::REG_ALPHA:       prdata = {16'd0, alpha};
			fecrs_pkg::REG_BETA:        prdata = {16'd0, beta};
			default:                    prdata = '0;
		endcase
	end

	fecrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_action (in_ch.action),
		.in_ready  (in_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fecrs_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.cfg                  (cfg),
		.max_window           (max_window),
		.window_step          (window_step),
		.alpha                (alpha),
		.beta                 (beta),
		.in_pkt_length        (in_ch.pkt_length),
		.in_fb_window         (in_ch.fb_window),
		.in_fb_active_windows (in_ch.fb_active_windows),
		.in_fb_losses         (in_ch.fb_losses),
		.in_fb_losses_squared (in_ch.fb_losses_squared),
		.out_ready            (out_ch.ready),
		.out_valid            (out_ch.valid),
		.out_source_id        (out_ch.source_id),
		.out_send_repair      (out_ch.send_repair),
		.out_repair_window    (out_ch.repair_window),
		.out_repair_info      (out_ch.repair_info),
		.out_repair_length    (out_ch.repair_length)
	);

endmodule
